// ----- rtl/door_lock_command_controller_macros.svh -----
// Assertion macros for the door lock command controller checker.
// Plain text only; no dependencies.
`ifndef DOOR_LOCK_COMMAND_CONTROLLER_MACROS_SVH
`define DOOR_LOCK_COMMAND_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define DLCC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dlcc: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define DLCC_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dlcc: next-cycle check failed");

`endif

// ----- rtl/dlcc_pkg.sv -----
// Shared types, codes and constants of the door lock command controller.
// No dependencies.
package dlcc_pkg;

    localparam int TIMER_W = 16;
    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_W) - 33'd1;
    localparam logic [TIMER_W-1:0] TIMER_ONE = TIMER_W'(1);
    localparam logic [TIMER_W-1:0] TIMER_ZERO = '0;

    // Item kinds, same encoding as func
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_PRESS = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Command characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_CEE   = 8'h43;

    // Character classes kept in the command window
    localparam logic [2:0] CC_OTHER = 3'd0;
    localparam logic [2:0] CC_HASH  = 3'd1;
    localparam logic [2:0] CC_STAR  = 3'd2;
    localparam logic [2:0] CC_ZERO  = 3'd3;
    localparam logic [2:0] CC_CEE   = 3'd4;
    localparam logic [2:0] CC_ONE   = 3'd5;
    localparam logic [2:0] CC_EIGHT = 3'd6;

    // Result events
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_ARMED      = 4'd1;
    localparam logic [3:0] EV_CMD_OPEN   = 4'd2;
    localparam logic [3:0] EV_CMD_CLOSE  = 4'd3;
    localparam logic [3:0] EV_STATUS     = 4'd4;
    localparam logic [3:0] EV_RESET      = 4'd5;
    localparam logic [3:0] EV_INVALID    = 4'd6;
    localparam logic [3:0] EV_LOCK_START = 4'd7;
    localparam logic [3:0] EV_LOCK_END   = 4'd8;
    localparam logic [3:0] EV_BTN_CLOSE  = 4'd9;
    localparam logic [3:0] EV_BTN_OPEN   = 4'd10;
    localparam logic [3:0] EV_HELD_OPEN  = 4'd11;
    localparam logic [3:0] EV_AUTO_CLOSE = 4'd12;

    // Register indexes
    localparam logic [2:0] REG_OPEN_TIME    = 3'd0;
    localparam logic [2:0] REG_PRESS_WINDOW = 3'd1;
    localparam logic [2:0] REG_DEBOUNCE     = 3'd2;
    localparam logic [2:0] REG_LOCKOUT      = 3'd3;
    localparam logic [2:0] REG_MAX_MISTAKES = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_OPEN_TIME    = 16'd5000;
    localparam logic [15:0] RST_PRESS_WINDOW = 16'd500;
    localparam logic [15:0] RST_DEBOUNCE     = 16'd200;
    localparam logic [15:0] RST_LOCKOUT      = 16'd10000;
    localparam logic [3:0]  RST_MAX_MISTAKES = 4'd5;

    localparam logic [3:0] MISTAKE_SAT = 4'd15;
    localparam logic [1:0] PRESS_SAT   = 2'd3;
    localparam logic [1:0] FILL_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] code;
    } item_t;

    typedef struct packed {
        logic [3:0] event_res;
        logic       door_open;
        logic       door_held;
        logic       armed;
        logic [3:0] tries_left;
        logic       locked_out;
    } res_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [15:0] data;
    } cfg_wr_t;

    function automatic logic [TIMER_W-1:0] load_timer(input logic [15:0] v);
        logic [32:0] wide;
        wide = {17'd0, v};
        if (wide > TIMER_MAX)
            return '1;
        return wide[TIMER_W-1:0];
    endfunction

endpackage

// ----- rtl/dlcc_front.sv -----
// Front end: takes input words, classifies kind and character, queues them.
// Depends on dlcc_pkg.
module dlcc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     func,
    input  logic [7:0]     data_byte,
    output logic           item_valid,
    output dlcc_pkg::item_t item,
    input  logic           item_take
);

    dlcc_pkg::item_t cls;
    dlcc_pkg::item_t q_mem [2];
    logic            rd_ptr_reg, rd_ptr_next;
    logic            wr_ptr_reg, wr_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            do_push, do_pop;

    always_comb
    begin
        cls.kind = func;
        unique case (data_byte)
            dlcc_pkg::CH_HASH:  cls.code = dlcc_pkg::CC_HASH;
            dlcc_pkg::CH_STAR:  cls.code = dlcc_pkg::CC_STAR;
            dlcc_pkg::CH_ZERO:  cls.code = dlcc_pkg::CC_ZERO;
            dlcc_pkg::CH_CEE:   cls.code = dlcc_pkg::CC_CEE;
            dlcc_pkg::CH_ONE:   cls.code = dlcc_pkg::CC_ONE;
            dlcc_pkg::CH_EIGHT: cls.code = dlcc_pkg::CC_EIGHT;
            default:            cls.code = dlcc_pkg::CC_OTHER;
        endcase
    end

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= cls;
    end

endmodule

// ----- rtl/dlcc_back.sv -----
// Back end: runs queued items against the lock state and queues results.
// Holds the configuration registers. Depends on dlcc_pkg.
module dlcc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  dlcc_pkg::cfg_wr_t cfg,
    input  logic             item_valid,
    input  dlcc_pkg::item_t  item,
    output logic             item_take,
    output logic             empty,
    input  logic             pop,
    output dlcc_pkg::res_t   res
);

    localparam int TW = dlcc_pkg::TIMER_W;

    // configuration
    logic [15:0] open_time_reg, press_window_reg, debounce_reg, lockout_reg;
    logic [3:0]  max_mist_reg;

    // lock state
    logic [2:0]    win_reg [3];
    logic [2:0]    win_next [3];
    logic [1:0]    fill_reg, fill_next;
    logic          armed_reg, armed_next;
    logic [3:0]    mist_reg, mist_next;
    logic          door_reg, door_next;
    logic          held_reg, held_next;
    logic [TW-1:0] otim_reg, otim_next;
    logic          timing_reg, timing_next;
    logic [1:0]    pc_reg, pc_next;
    logic [TW-1:0] ptim_reg, ptim_next;
    logic [TW-1:0] deb_reg, deb_next;
    logic [TW-1:0] ltim_reg, ltim_next;
    logic          lock_reg, lock_next;
    logic [3:0]    ev;
    logic          lock_end, auto_close, classify;
    logic [1:0]    fill_inc;

    // result queue
    dlcc_pkg::res_t r_mem [2];
    dlcc_pkg::res_t r_new;
    logic           rd_ptr_reg, wr_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           exec, do_pop;

    assign exec      = item_valid && (cnt_reg != 2'd2);
    assign item_take = exec;
    assign empty     = (cnt_reg == 2'd0);
    assign do_pop    = pop && !empty;
    assign res       = r_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_time_reg    <= dlcc_pkg::RST_OPEN_TIME;
            press_window_reg <= dlcc_pkg::RST_PRESS_WINDOW;
            debounce_reg     <= dlcc_pkg::RST_DEBOUNCE;
            lockout_reg      <= dlcc_pkg::RST_LOCKOUT;
            max_mist_reg     <= dlcc_pkg::RST_MAX_MISTAKES;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                dlcc_pkg::REG_OPEN_TIME:    open_time_reg    <= cfg.data;
                dlcc_pkg::REG_PRESS_WINDOW: press_window_reg <= cfg.data;
                dlcc_pkg::REG_DEBOUNCE:     debounce_reg     <= cfg.data;
                dlcc_pkg::REG_LOCKOUT:      lockout_reg      <= cfg.data;
                dlcc_pkg::REG_MAX_MISTAKES: max_mist_reg     <= cfg.data[3:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        win_next    = win_reg;
        fill_next   = fill_reg;
        armed_next  = armed_reg;
        mist_next   = mist_reg;
        door_next   = door_reg;
        held_next   = held_reg;
        otim_next   = otim_reg;
        timing_next = timing_reg;
        pc_next     = pc_reg;
        ptim_next   = ptim_reg;
        deb_next    = deb_reg;
        ltim_next   = ltim_reg;
        lock_next   = lock_reg;
        ev          = dlcc_pkg::EV_NONE;
        lock_end    = 1'b0;
        auto_close  = 1'b0;
        classify    = 1'b0;
        fill_inc    = (fill_reg == dlcc_pkg::FILL_FULL) ? fill_reg : fill_reg + 2'd1;

        unique case (item.kind)
            dlcc_pkg::KIND_BYTE:
            begin
                if (!lock_reg)
                begin
                    // shifted window is win_reg[1], win_reg[2], item.code
                    priority if (win_reg[1] == dlcc_pkg::CC_HASH
                                 && win_reg[2] == dlcc_pkg::CC_STAR
                                 && item.code == dlcc_pkg::CC_HASH)
                    begin
                        armed_next = 1'b1;
                        ev         = dlcc_pkg::EV_ARMED;
                    end
                    else if (!armed_reg || win_reg[1] != dlcc_pkg::CC_HASH
                             || item.code != dlcc_pkg::CC_HASH
                             || !(win_reg[2] == dlcc_pkg::CC_ZERO
                                  || win_reg[2] == dlcc_pkg::CC_CEE
                                  || win_reg[2] == dlcc_pkg::CC_EIGHT
                                  || win_reg[2] == dlcc_pkg::CC_ONE))
                    begin
                        // no command: slide, or count a mistake on a full window
                        ev = dlcc_pkg::EV_NONE;
                    end
                    else if (win_reg[2] == dlcc_pkg::CC_ZERO)
                    begin
                        door_next   = 1'b1;
                        held_next   = 1'b0;
                        otim_next   = dlcc_pkg::load_timer(open_time_reg);
                        timing_next = 1'b1;
                        ev          = dlcc_pkg::EV_CMD_OPEN;
                    end
                    else if (win_reg[2] == dlcc_pkg::CC_ONE)
                    begin
                        ev = dlcc_pkg::EV_STATUS;
                    end
                    else
                    begin
                        door_next   = 1'b0;
                        held_next   = 1'b0;
                        timing_next = 1'b0;
                        otim_next   = dlcc_pkg::TIMER_ZERO;
                        ev = (win_reg[2] == dlcc_pkg::CC_CEE) ? dlcc_pkg::EV_CMD_CLOSE
                                                               : dlcc_pkg::EV_RESET;
                    end

                    if (ev != dlcc_pkg::EV_NONE)
                    begin
                        win_next[0] = dlcc_pkg::CC_OTHER;
                        win_next[1] = dlcc_pkg::CC_OTHER;
                        win_next[2] = dlcc_pkg::CC_OTHER;
                        fill_next   = 2'd0;
                        mist_next   = 4'd0;
                    end
                    else if (!armed_reg || fill_inc != dlcc_pkg::FILL_FULL)
                    begin
                        win_next[0] = win_reg[1];
                        win_next[1] = win_reg[2];
                        win_next[2] = item.code;
                        fill_next   = fill_inc;
                    end
                    else
                    begin
                        win_next[0] = dlcc_pkg::CC_OTHER;
                        win_next[1] = dlcc_pkg::CC_OTHER;
                        win_next[2] = dlcc_pkg::CC_OTHER;
                        fill_next   = 2'd0;
                        if (mist_reg != dlcc_pkg::MISTAKE_SAT)
                            mist_next = mist_reg + 4'd1;
                        if (mist_next >= max_mist_reg)
                        begin
                            lock_next = 1'b1;
                            ltim_next = dlcc_pkg::load_timer(lockout_reg);
                            ev        = dlcc_pkg::EV_LOCK_START;
                        end
                        else
                        begin
                            ev = dlcc_pkg::EV_INVALID;
                        end
                    end
                end
            end
            dlcc_pkg::KIND_PRESS:
            begin
                if (deb_reg == dlcc_pkg::TIMER_ZERO)
                begin
                    deb_next  = dlcc_pkg::load_timer(debounce_reg);
                    pc_next   = (pc_reg == dlcc_pkg::PRESS_SAT) ? pc_reg : pc_reg + 2'd1;
                    ptim_next = dlcc_pkg::load_timer(press_window_reg);
                end
            end
            dlcc_pkg::KIND_TICK:
            begin
                if (deb_reg != dlcc_pkg::TIMER_ZERO)
                    deb_next = deb_reg - dlcc_pkg::TIMER_ONE;
                if (lock_reg)
                begin
                    if (ltim_reg != dlcc_pkg::TIMER_ZERO)
                        ltim_next = ltim_reg - dlcc_pkg::TIMER_ONE;
                    if (ltim_next == dlcc_pkg::TIMER_ZERO)
                    begin
                        lock_next = 1'b0;
                        mist_next = 4'd0;
                        lock_end  = 1'b1;
                    end
                end
                if (timing_reg && !held_reg)
                begin
                    if (otim_reg != dlcc_pkg::TIMER_ZERO)
                        otim_next = otim_reg - dlcc_pkg::TIMER_ONE;
                    if (otim_next == dlcc_pkg::TIMER_ZERO)
                    begin
                        door_next   = 1'b0;
                        timing_next = 1'b0;
                        auto_close  = 1'b1;
                    end
                end
                if (pc_reg != 2'd0)
                begin
                    if (ptim_reg != dlcc_pkg::TIMER_ZERO)
                        ptim_next = ptim_reg - dlcc_pkg::TIMER_ONE;
                    if (ptim_next == dlcc_pkg::TIMER_ZERO)
                    begin
                        classify = 1'b1;
                        pc_next  = 2'd0;
                        priority if (pc_reg != 2'd1)
                        begin
                            door_next   = 1'b1;
                            held_next   = 1'b1;
                            timing_next = 1'b0;
                            otim_next   = dlcc_pkg::TIMER_ZERO;
                            ev          = dlcc_pkg::EV_HELD_OPEN;
                        end
                        else if (held_reg)
                        begin
                            door_next   = 1'b0;
                            held_next   = 1'b0;
                            timing_next = 1'b0;
                            otim_next   = dlcc_pkg::TIMER_ZERO;
                            ev          = dlcc_pkg::EV_BTN_CLOSE;
                        end
                        else
                        begin
                            door_next   = 1'b1;
                            otim_next   = dlcc_pkg::load_timer(open_time_reg);
                            timing_next = 1'b1;
                            ev          = dlcc_pkg::EV_BTN_OPEN;
                        end
                    end
                end
                // button classification outranks auto-close, then lockout end
                if (!classify)
                begin
                    priority if (auto_close)
                        ev = dlcc_pkg::EV_AUTO_CLOSE;
                    else if (lock_end)
                        ev = dlcc_pkg::EV_LOCK_END;
                    else
                        ev = dlcc_pkg::EV_NONE;
                end
            end
            default:
            begin
                ev = dlcc_pkg::EV_NONE;
            end
        endcase

        r_new.event_res  = ev;
        r_new.door_open  = door_next;
        r_new.door_held  = held_next;
        r_new.armed      = armed_next;
        r_new.tries_left = (max_mist_reg > mist_next) ? max_mist_reg - mist_next : 4'd0;
        r_new.locked_out = lock_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= dlcc_pkg::CC_OTHER;
            win_reg[1] <= dlcc_pkg::CC_OTHER;
            win_reg[2] <= dlcc_pkg::CC_OTHER;
            fill_reg   <= 2'd0;
            armed_reg  <= 1'b0;
            mist_reg   <= 4'd0;
            door_reg   <= 1'b0;
            held_reg   <= 1'b0;
            otim_reg   <= dlcc_pkg::TIMER_ZERO;
            timing_reg <= 1'b0;
            pc_reg     <= 2'd0;
            ptim_reg   <= dlcc_pkg::TIMER_ZERO;
            deb_reg    <= dlcc_pkg::TIMER_ZERO;
            ltim_reg   <= dlcc_pkg::TIMER_ZERO;
            lock_reg   <= 1'b0;
        end
        else if (exec)
        begin
            win_reg    <= win_next;
            fill_reg   <= fill_next;
            armed_reg  <= armed_next;
            mist_reg   <= mist_next;
            door_reg   <= door_next;
            held_reg   <= held_next;
            otim_reg   <= otim_next;
            timing_reg <= timing_next;
            pc_reg     <= pc_next;
            ptim_reg   <= ptim_next;
            deb_reg    <= deb_next;
            ltim_reg   <= ltim_next;
            lock_reg   <= lock_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (exec)
                wr_ptr_reg <= ~wr_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, exec} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
            r_mem[wr_ptr_reg] <= r_new;
    end

endmodule

// ----- rtl/door_lock_command_controller.sv -----
// Top level of the door lock command controller: front queue plus back end.
// Depends on dlcc_pkg, dlcc_front, dlcc_back.
//
//  channel   handshake              word
//  input     push / full            func, data_byte
//  result    empty / pop            event_res, door_open, door_held, armed,
//                                   tries_left, locked_out
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while results are popped: a word is
// classified on entry, waits in a two-entry queue, and the back end updates
// the lock state and registers its result; results sit in a two-entry
// queue. A stalled result side fills both queues before full rises.
// Reset clears all lock state and loads the register defaults; cfg_ready is
// always high.
module door_lock_command_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  event_res,
    output logic        door_open,
    output logic        door_held,
    output logic        armed,
    output logic [3:0]  tries_left,
    output logic        locked_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dlcc_pkg::item_t   item;
    dlcc_pkg::res_t    res;
    dlcc_pkg::cfg_wr_t cfg;
    logic              item_valid;
    logic              item_take;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    dlcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .data_byte  (data_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    dlcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    assign event_res  = res.event_res;
    assign door_open  = res.door_open;
    assign door_held  = res.door_held;
    assign armed      = res.armed;
    assign tries_left = res.tries_left;
    assign locked_out = res.locked_out;

endmodule

// ----- rtl/dlcc_checker.sv -----
// Port-level checks of the door lock command controller, bound to the top.
// Depends on dlcc_pkg and door_lock_command_controller_macros.svh.
`include "door_lock_command_controller_macros.svh"

module dlcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  event_res,
    input logic        door_open,
    input logic        door_held,
    input logic        armed,
    input logic [3:0]  tries_left,
    input logic        locked_out
);

    logic res_valid;
    logic lock_ev;
    logic open_ev;
    logic close_ev;
    logic lock_shown;
    logic closed_shown;

    assign res_valid    = !empty;
    assign lock_ev      = res_valid && event_res == dlcc_pkg::EV_LOCK_START;
    assign open_ev      = res_valid && (event_res == dlcc_pkg::EV_CMD_OPEN
                                        || event_res == dlcc_pkg::EV_BTN_OPEN
                                        || event_res == dlcc_pkg::EV_HELD_OPEN);
    assign close_ev     = res_valid && (event_res == dlcc_pkg::EV_CMD_CLOSE
                                        || event_res == dlcc_pkg::EV_RESET
                                        || event_res == dlcc_pkg::EV_BTN_CLOSE);
    assign lock_shown   = locked_out && tries_left == 4'd0 && armed;
    assign closed_shown = !door_open && !door_held;

    // a waiting word stays until popped
    `DLCC_ASSERT_NXT(a_res_holds, clk, rst_n, res_valid && !pop, res_valid)

    `DLCC_ASSERT_IMP(a_lock_start, clk, rst_n, lock_ev, lock_shown)

    `DLCC_ASSERT_IMP(a_open_events, clk, rst_n, open_ev, door_open)

    `DLCC_ASSERT_IMP(a_close_events, clk, rst_n, close_ev, closed_shown)

    `DLCC_ASSERT_IMP(a_held_open, clk, rst_n, res_valid && door_held, door_open)

endmodule

bind door_lock_command_controller dlcc_checker u_dlcc_checker (.*);

// ----- tb/door_lock_command_controller_tb.sv -----
// Testbench for door_lock_command_controller. It pushes command bytes, button presses and
// millisecond ticks, and checks every status word against a lock model kept in the bench.
// Depends on dlcc_pkg and the controller RTL.
import dlcc_pkg::*;

class lock_status_board;
    logic [15:0] open_time, press_window, debounce, lockout;
    logic [3:0]  max_mistakes;

    logic [7:0]  cmd_win [3];
    int          fill;
    bit          armed_q, door_q, held_q, open_timing_q, lock_q;
    logic [3:0]  mistakes;
    logic [1:0]  presses;
    logic [15:0] open_tmr, press_tmr, deb_tmr, lock_tmr;

    res_t        expected_status [$];
    int          errors;

    function new();
        open_time     = RST_OPEN_TIME;
        press_window  = RST_PRESS_WINDOW;
        debounce      = RST_DEBOUNCE;
        lockout       = RST_LOCKOUT;
        max_mistakes  = RST_MAX_MISTAKES;
        clear_window();
        armed_q       = 1'b0;
        door_q        = 1'b0;
        held_q        = 1'b0;
        open_timing_q = 1'b0;
        lock_q        = 1'b0;
        mistakes      = '0;
        presses       = '0;
        open_tmr      = '0;
        press_tmr     = '0;
        deb_tmr       = '0;
        lock_tmr      = '0;
        errors        = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [15:0] data);
        case (idx)
            REG_OPEN_TIME:    open_time = data;
            REG_PRESS_WINDOW: press_window = data;
            REG_DEBOUNCE:     debounce = data;
            REG_LOCKOUT:      lockout = data;
            REG_MAX_MISTAKES: max_mistakes = data[3:0];
            default:          ;
        endcase
    endfunction

    function void clear_window();
        cmd_win[0] = '0;
        cmd_win[1] = '0;
        cmd_win[2] = '0;
        fill = 0;
    endfunction

    function bit window_is(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        return cmd_win[0] == a && cmd_win[1] == b && cmd_win[2] == c;
    endfunction

    function logic [3:0] take_byte(logic [7:0] b);
        logic [3:0] ev;
        if (lock_q)
            return EV_NONE;
        cmd_win[0] = cmd_win[1];
        cmd_win[1] = cmd_win[2];
        cmd_win[2] = b;
        if (fill < 3)
            fill++;
        if (window_is(CH_HASH, CH_STAR, CH_HASH))
        begin
            armed_q = 1'b1;
            clear_window();
            mistakes = '0;
            return EV_ARMED;
        end
        if (!armed_q)
            return EV_NONE;
        if (window_is(CH_HASH, CH_ZERO, CH_HASH))
        begin
            door_q = 1'b1;
            held_q = 1'b0;
            open_tmr = open_time;
            open_timing_q = 1'b1;
            clear_window();
            mistakes = '0;
            return EV_CMD_OPEN;
        end
        if (window_is(CH_HASH, CH_CEE, CH_HASH) || window_is(CH_HASH, CH_EIGHT, CH_HASH))
        begin
            ev = (cmd_win[1] == CH_CEE) ? EV_CMD_CLOSE : EV_RESET;
            door_q = 1'b0;
            held_q = 1'b0;
            open_timing_q = 1'b0;
            open_tmr = '0;
            clear_window();
            mistakes = '0;
            return ev;
        end
        if (window_is(CH_HASH, CH_ONE, CH_HASH))
        begin
            clear_window();
            mistakes = '0;
            return EV_STATUS;
        end
        if (fill < 3)
            return EV_NONE;
        // full window with no match: count a mistake, saturating
        if (mistakes < MISTAKE_SAT)
            mistakes++;
        clear_window();
        if (mistakes >= max_mistakes)
        begin
            lock_q = 1'b1;
            lock_tmr = lockout;
            return EV_LOCK_START;
        end
        return EV_INVALID;
    endfunction

    function void take_press();
        if (deb_tmr != 0)
            return;
        deb_tmr = debounce;
        if (presses < PRESS_SAT)
            presses++;
        press_tmr = press_window;
    endfunction

    function logic [3:0] take_tick();
        logic [3:0] ev;
        bit lock_end, auto_close, classify;
        ev = EV_NONE;
        lock_end = 1'b0;
        auto_close = 1'b0;
        classify = 1'b0;
        if (deb_tmr != 0)
            deb_tmr--;
        if (lock_q)
        begin
            if (lock_tmr != 0)
                lock_tmr--;
            if (lock_tmr == 0)
            begin
                lock_q = 1'b0;
                mistakes = '0;
                lock_end = 1'b1;
            end
        end
        if (open_timing_q && !held_q)
        begin
            if (open_tmr != 0)
                open_tmr--;
            if (open_tmr == 0)
            begin
                door_q = 1'b0;
                open_timing_q = 1'b0;
                auto_close = 1'b1;
            end
        end
        if (presses != 0)
        begin
            if (press_tmr != 0)
                press_tmr--;
            if (press_tmr == 0)
            begin
                classify = 1'b1;
                if (presses == 1)
                begin
                    if (held_q)
                    begin
                        door_q = 1'b0;
                        held_q = 1'b0;
                        open_timing_q = 1'b0;
                        open_tmr = '0;
                        ev = EV_BTN_CLOSE;
                    end
                    else
                    begin
                        door_q = 1'b1;
                        open_tmr = open_time;
                        open_timing_q = 1'b1;
                        ev = EV_BTN_OPEN;
                    end
                end
                else
                begin
                    door_q = 1'b1;
                    held_q = 1'b1;
                    open_timing_q = 1'b0;
                    open_tmr = '0;
                    ev = EV_HELD_OPEN;
                end
                presses = '0;
            end
        end
        // button classification wins over auto-close, which wins over lockout end
        if (classify)
            return ev;
        if (auto_close)
            return EV_AUTO_CLOSE;
        if (lock_end)
            return EV_LOCK_END;
        return EV_NONE;
    endfunction

    function void note_word(logic [1:0] f, logic [7:0] b);
        res_t r;
        r.event_res = EV_NONE;
        case (f)
            KIND_BYTE:  r.event_res = take_byte(b);
            KIND_PRESS: take_press();
            KIND_TICK:  r.event_res = take_tick();
            default:    ;
        endcase
        r.door_open  = door_q;
        r.door_held  = held_q;
        r.armed      = armed_q;
        r.tries_left = (max_mistakes > mistakes) ? max_mistakes - mistakes : 4'd0;
        r.locked_out = lock_q;
        expected_status.push_back(r);
    endfunction

    function void check_word(res_t got);
        res_t want;
        if (expected_status.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("status word with nothing outstanding: ev=%0d", got.event_res);
            return;
        end
        want = expected_status.pop_front();
        if (got.event_res !== want.event_res || got.door_open !== want.door_open ||
            got.door_held !== want.door_held || got.armed !== want.armed ||
            got.tries_left !== want.tries_left || got.locked_out !== want.locked_out)
        begin
            errors++;
            if (errors <= 10)
                $display({"status mismatch: expected ev=%0d open=%0b held=%0b armed=%0b ",
                          "tries=%0d lock=%0b, got ev=%0d open=%0b held=%0b armed=%0b ",
                          "tries=%0d lock=%0b"},
                         want.event_res, want.door_open, want.door_held, want.armed,
                         want.tries_left, want.locked_out,
                         got.event_res, got.door_open, got.door_held, got.armed,
                         got.tries_left, got.locked_out);
        end
    endfunction

    function int pending();
        return expected_status.size();
    endfunction
endclass

module door_lock_command_controller_tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [1:0]  func = KIND_BYTE;
    logic [7:0]  data_byte = '0;
    logic        pop = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = REG_OPEN_TIME;
    logic [15:0] cfg_data = '0;
    logic        full, empty, cfg_ready;
    logic [3:0]  event_res, tries_left;
    logic        door_open, door_held, armed, locked_out;

    int send_idle_pct = 22;
    int recv_idle_pct = 59;
    int useful_words = 0;
    lock_status_board board = new();

    door_lock_command_controller DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .data_byte  (data_byte),
        .empty      (empty),
        .pop        (pop),
        .event_res  (event_res),
        .door_open  (door_open),
        .door_held  (door_held),
        .armed      (armed),
        .tries_left (tries_left),
        .locked_out (locked_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] command_char();
        case ($urandom_range(5))
            0:       return CH_HASH;
            1:       return CH_STAR;
            2:       return CH_ZERO;
            3:       return CH_CEE;
            4:       return CH_ONE;
            default: return CH_EIGHT;
        endcase
    endfunction

    task automatic send_word(input logic [1:0] f, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        func <= f;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        // bytes swallowed by a lockout do not advance the phase
        if (!(f == KIND_BYTE && board.lock_q))
            useful_words++;
        board.note_word(f, b);
    endtask

    task automatic send_cmd(input logic [7:0] mid);
        send_word(KIND_BYTE, CH_HASH);
        send_word(KIND_BYTE, mid);
        send_word(KIND_BYTE, CH_HASH);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_register(idx, data);
    endtask

    task automatic configure(input logic [15:0] open_ms, input logic [15:0] window_ms,
                             input logic [15:0] bounce_ms, input logic [15:0] lock_ms,
                             input logic [15:0] mistake_limit);
        drain_results();
        write_reg(REG_OPEN_TIME, open_ms);
        write_reg(REG_PRESS_WINDOW, window_ms);
        write_reg(REG_DEBOUNCE, bounce_ms);
        write_reg(REG_LOCKOUT, lock_ms);
        write_reg(REG_MAX_MISTAKES, mistake_limit);
        // unmapped indexes must leave every setting alone
        for (int i = REG_MAX_MISTAKES + 1; i < 8; i++)
            write_reg(3'(i), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic();
        int pick, n;
        logic [7:0] mid;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            mid = command_char();
            if (!board.armed_q && $urandom_range(1))
                mid = CH_STAR;
            send_word(KIND_BYTE, CH_HASH);
            send_word(KIND_BYTE, ($urandom_range(9) == 0) ? 8'($urandom) : mid);
            send_word(KIND_BYTE, CH_HASH);
        end
        else if (pick < 60)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_word(KIND_BYTE, $urandom_range(1) ? 8'($urandom) : command_char());
        end
        else if (pick < 85)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 8);
            repeat (n)
                send_word(KIND_TICK, 8'($urandom));
        end
        else if (pick < 97)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                send_word(KIND_PRESS, 8'($urandom));
                repeat ($urandom_range(0, 2))
                    send_word(KIND_TICK, 8'($urandom));
            end
        end
        else
            send_word(KIND_NONE, 8'($urandom));
    endtask

    task automatic run_phase(input int words);
        int target;
        target = useful_words + words;
        while (useful_words < target)
            random_traffic();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: unknown kind, unarmed sliding, then every command
        send_word(KIND_NONE, 8'hFF);
        send_cmd(CH_ZERO);
        send_word(KIND_BYTE, CH_STAR);
        send_word(KIND_BYTE, CH_HASH);
        send_cmd(CH_ONE);
        send_word(KIND_BYTE, 8'h00);
        send_word(KIND_BYTE, 8'hFF);
        send_word(KIND_BYTE, 8'h80);
        send_cmd(CH_ZERO);
        send_cmd(CH_CEE);
        send_cmd(CH_EIGHT);
        send_word(KIND_TICK, 8'h55);

        configure(16'd5, 16'd3, 16'd1, 16'd8, 16'd3);
        run_phase(275);
        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFF0);
        run_phase(275);

        send_idle_pct = 59;
        recv_idle_pct = 22;
        configure(16'($urandom_range(1, 30)), 16'($urandom_range(1, 12)),
                  16'($urandom_range(0, 6)), 16'($urandom_range(1, 40)),
                  16'($urandom_range(1, 15)));
        run_phase(275);
        configure(16'd1, 16'd1, 16'd1, 16'd1, 16'h000F);
        run_phase(275);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(16'($urandom_range(1, 200)), 16'($urandom_range(1, 40)),
                  16'($urandom_range(0, 20)), 16'($urandom_range(1, 200)),
                  16'($urandom_range(1, 15)));
        run_phase(275);
        // widest settings last: long timers would starve later phases
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(275);

        drain_results();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("door_lock_command_controller_tb: clean");
        else
            $display("door_lock_command_controller_tb: errors");
        $finish;
    end

    initial
    begin
        res_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.event_res  = event_res;
                got.door_open  = door_open;
                got.door_held  = door_held;
                got.armed      = armed;
                got.tries_left = tries_left;
                got.locked_out = locked_out;
                board.check_word(got);
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("door_lock_command_controller_tb: errors");
        $finish;
    end
endmodule
